[hdl/stq_pkg.sv]
// Shared constants, field widths and operation codes of the sorted timer queue.
package stq_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    localparam int FUNC_W      = 2;
    localparam int ID_W        = 4;
    localparam int FIELD_T_W   = 32;
    localparam int IN_RAW_W    = ID_W + 2 * FIELD_T_W;
    localparam int IN_DATA_W   = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W   = ID_W + FIELD_T_W;
    localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD = 2'd0,
        FUNC_DEL = 2'd1,
        FUNC_RUN = 2'd2
    } func_t;

    typedef enum logic {
        KIND_FIRED   = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

endpackage

[hdl/sorted_timer_queue.sv]
// Sorted timer queue: expiry-ordered list of timers walked by a small sequencer.
// Add, delete and run items arrive on the s_ side; run results leave on the m_ side.
// The slot order and the expiry times sit in two single-port memories with registered
// reads, and the sequencer works through the list an entry at a time. Every item is
// first accepted while idle. A delete then checks each listed entry as it walks to the
// end of the list. An add of a new timer reads the order and expiry of each entry from
// the tail and compares, shifting it down until the new slot is written in its place;
// re-adding a listed timer first does the delete walk. A run reads and compares each
// examined entry the same way (fired timers also wait for the result to be taken), goes
// straight to the summary when every entry fires, copies each surviving entry to the
// front once some have fired, and sends the summary once the output is free. The chained
// order-then-expiry read sets the per-entry cost. Both stores need no clearing after
// reset; the block is ready in the first cycle after reset. Input is not taken while an
// item is being worked; a waiting result does not stop the next item from entering.
module sorted_timer_queue #(
    parameter int TIMER_SLOTS = stq_pkg::TIMER_SLOTS_DEF,
    parameter int TIME_BITS   = stq_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [stq_pkg::IN_DATA_W-1:0]   s_tdata,  // timer_id, expire_time, now_time, pad
    input  logic [stq_pkg::FUNC_W-1:0]      s_tuser,  // func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [stq_pkg::OUT_DATA_W-1:0]  m_tdata,  // fired_id, wake_delay, pad
    output logic                            m_tuser,  // kind
    output logic                            m_tlast
);

    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
    localparam int ID_W   = stq_pkg::ID_W;
    localparam int FT_W   = stq_pkg::FIELD_T_W;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_UL_RD  = 12'b0000_0000_0010,
        ST_UL_CHK = 12'b0000_0000_0100,
        ST_IN_RD  = 12'b0000_0000_1000,
        ST_IN_EXP = 12'b0000_0001_0000,
        ST_IN_CMP = 12'b0000_0010_0000,
        ST_RN_RD  = 12'b0000_0100_0000,
        ST_RN_EXP = 12'b0000_1000_0000,
        ST_RN_CMP = 12'b0001_0000_0000,
        ST_CP_RD  = 12'b0010_0000_0000,
        ST_CP_WR  = 12'b0100_0000_0000,
        ST_SUM    = 12'b1000_0000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       wp_reg, wp_next;
    logic                   found_reg, found_next;
    logic                   add_reg, add_next;
    logic                   head_reg, head_next;
    logic [TIMER_SLOTS-1:0] listed_reg, listed_next;
    logic [SLOT_W-1:0]      id_reg, id_next;
    logic [TIME_BITS-1:0]   exp_reg, exp_next;
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic [TIME_BITS-1:0]   head_exp_reg, head_exp_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_kind_reg, out_kind_next;
    logic                   out_last_reg, out_last_next;
    logic [ID_W-1:0]        out_id_reg, out_id_next;
    logic [FT_W-1:0]        out_next_reg, out_next_next;

    logic [SLOT_W-1:0]      order_mem [0:TIMER_SLOTS-1];
    logic [TIME_BITS-1:0]   expiry_mem [0:TIMER_SLOTS-1];
    logic [SLOT_W-1:0]      ord_rd_reg;
    logic [TIME_BITS-1:0]   exp_rd_reg;

    logic                   ord_rd_en, ord_wr_en, exp_rd_en, exp_wr_en;
    logic [SLOT_W-1:0]      ord_rd_addr, ord_wr_addr, ord_wr_data, exp_rd_addr;

    logic                   in_beat, out_free;
    logic [ID_W-1:0]        in_id;
    logic [SLOT_W-1:0]      in_slot;
    logic                   in_range;
    logic [TIME_BITS-1:0]   in_exp, in_now, time_diff;
    logic [CNT_W-1:0]       idx_dec, cnt_dec;
    stq_pkg::func_t         in_func;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign in_func  = stq_pkg::func_t'(s_tuser);
    assign in_id    = s_tdata[ID_W-1:0];
    assign in_slot  = SLOT_W'(in_id);
    assign in_range = (32'(in_id) < TIMER_SLOTS);
    assign in_exp   = TIME_BITS'(s_tdata[ID_W +: FT_W]);
    assign in_now   = TIME_BITS'(s_tdata[ID_W + FT_W +: FT_W]);
    assign idx_dec  = idx_reg - CNT_W'(1);
    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign time_diff = head_exp_reg - now_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = stq_pkg::OUT_DATA_W'({out_next_reg, out_id_reg});

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        wp_next       = wp_reg;
        found_next    = found_reg;
        add_next      = add_reg;
        head_next     = head_reg;
        listed_next   = listed_reg;
        id_next       = id_reg;
        exp_next      = exp_reg;
        now_next      = now_reg;
        head_exp_next = head_exp_reg;

        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        out_id_next    = out_id_reg;
        out_next_next  = out_next_reg;

        ord_rd_en   = 1'b0;
        ord_rd_addr = idx_reg[SLOT_W-1:0];
        ord_wr_en   = 1'b0;
        ord_wr_addr = idx_reg[SLOT_W-1:0];
        ord_wr_data = ord_rd_reg;
        exp_rd_en   = 1'b0;
        exp_rd_addr = ord_rd_reg;
        exp_wr_en   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    id_next    = in_slot;
                    exp_next   = in_exp;
                    now_next   = in_now;
                    found_next = 1'b0;
                    unique case (in_func)
                        stq_pkg::FUNC_ADD:
                        begin
                            if (in_range)
                            begin
                                exp_wr_en            = 1'b1;
                                listed_next[in_slot] = 1'b1;
                                add_next             = 1'b1;
                                if (listed_reg[in_slot])
                                begin
                                    idx_next   = '0;
                                    state_next = ST_UL_RD;
                                end
                                else if (cnt_reg != CNT_W'(TIMER_SLOTS))
                                begin
                                    idx_next   = cnt_reg;
                                    state_next = ST_IN_RD;
                                end
                            end
                        end
                        stq_pkg::FUNC_DEL:
                        begin
                            if (in_range && listed_reg[in_slot])
                            begin
                                listed_next[in_slot] = 1'b0;
                                add_next             = 1'b0;
                                idx_next             = '0;
                                state_next           = ST_UL_RD;
                            end
                        end
                        stq_pkg::FUNC_RUN:
                        begin
                            idx_next   = '0;
                            state_next = ST_RN_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_UL_RD:
            begin
                ord_rd_en  = 1'b1;
                state_next = ST_UL_CHK;
            end

            ST_UL_CHK:
            begin
                if (found_reg)
                begin
                    ord_wr_en   = 1'b1;
                    ord_wr_addr = idx_dec[SLOT_W-1:0];
                end
                found_next = found_reg || (ord_rd_reg == id_reg);
                idx_next   = idx_reg + CNT_W'(1);
                state_next = ST_UL_RD;
                if (idx_reg == cnt_dec)
                begin
                    cnt_next = cnt_dec;
                    if (add_reg)
                    begin
                        idx_next   = cnt_dec;
                        state_next = ST_IN_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_IN_RD:
            begin
                if (idx_reg == '0)
                begin
                    ord_wr_en   = 1'b1;
                    ord_wr_data = id_reg;
                    cnt_next    = cnt_reg + CNT_W'(1);
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ord_rd_en   = 1'b1;
                    ord_rd_addr = idx_dec[SLOT_W-1:0];
                    state_next  = ST_IN_EXP;
                end
            end

            ST_IN_EXP:
            begin
                exp_rd_en  = 1'b1;
                state_next = ST_IN_CMP;
            end

            ST_IN_CMP:
            begin
                ord_wr_en = 1'b1;
                if (exp_rd_reg >= exp_reg)
                begin
                    idx_next   = idx_dec;
                    state_next = ST_IN_RD;
                end
                else
                begin
                    ord_wr_data = id_reg;
                    cnt_next    = cnt_reg + CNT_W'(1);
                    state_next  = ST_IDLE;
                end
            end

            ST_RN_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    cnt_next   = '0;
                    head_next  = 1'b0;
                    state_next = ST_SUM;
                end
                else
                begin
                    ord_rd_en  = 1'b1;
                    state_next = ST_RN_EXP;
                end
            end

            ST_RN_EXP:
            begin
                exp_rd_en  = 1'b1;
                state_next = ST_RN_CMP;
            end

            ST_RN_CMP:
            begin
                if (exp_rd_reg > now_reg)
                begin
                    head_next     = 1'b1;
                    head_exp_next = exp_rd_reg;
                    wp_next       = '0;
                    state_next    = (idx_reg == '0) ? ST_SUM : ST_CP_RD;
                end
                else if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_kind_next           = stq_pkg::KIND_FIRED;
                    out_last_next           = 1'b0;
                    out_id_next             = ID_W'(ord_rd_reg);
                    out_next_next           = '0;
                    listed_next[ord_rd_reg] = 1'b0;
                    idx_next                = idx_reg + CNT_W'(1);
                    state_next              = ST_RN_RD;
                end
            end

            ST_CP_RD:
            begin
                ord_rd_en  = 1'b1;
                state_next = ST_CP_WR;
            end

            ST_CP_WR:
            begin
                ord_wr_en   = 1'b1;
                ord_wr_addr = wp_reg[SLOT_W-1:0];
                wp_next     = wp_reg + CNT_W'(1);
                idx_next    = idx_reg + CNT_W'(1);
                state_next  = ST_CP_RD;
                if (idx_reg == cnt_dec)
                begin
                    cnt_next   = wp_reg + CNT_W'(1);
                    state_next = ST_SUM;
                end
            end

            ST_SUM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = stq_pkg::KIND_SUMMARY;
                    out_last_next  = 1'b1;
                    out_id_next    = '0;
                    out_next_next  = head_reg ? FT_W'(time_diff) : '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            wp_reg        <= '0;
            found_reg     <= 1'b0;
            add_reg       <= 1'b0;
            head_reg      <= 1'b0;
            listed_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            wp_reg        <= wp_next;
            found_reg     <= found_next;
            add_reg       <= add_next;
            head_reg      <= head_next;
            listed_reg    <= listed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        exp_reg      <= exp_next;
        now_reg      <= now_next;
        head_exp_reg <= head_exp_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
        out_id_reg   <= out_id_next;
        out_next_reg <= out_next_next;
    end

    always_ff @(posedge clk)
    begin
        if (ord_wr_en)
        begin
            order_mem[ord_wr_addr] <= ord_wr_data;
        end
        if (ord_rd_en)
        begin
            ord_rd_reg <= order_mem[ord_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (exp_wr_en)
        begin
            expiry_mem[in_slot] <= in_exp;
        end
        if (exp_rd_en)
        begin
            exp_rd_reg <= expiry_mem[exp_rd_addr];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TIMER_SLOTS))
    else $error("list count beyond slot count");

    a_flags_match_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(listed_reg) == int'(cnt_reg)))
    else $error("listed flags disagree with list count");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == m_tuser))
    else $error("last marker not on summary beat");

    a_fired_no_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[ID_W +: FT_W] == '0))
    else $error("fired beat carries a timeout");

endmodule
